@@ rtl/core/prefix_code_bit_packer_core_defines.svh @@
//------------------------------------------------------------------------------
// Prefix code bit packer assertion macros
// Shared concurrent assertion forms for the packer core.
//------------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define PREFIX_CODE_BIT_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcbp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcbp: next-cycle check failed");

`endif

@@ rtl/core/pcbp_pkg.sv @@
//------------------------------------------------------------------------------
// Prefix code bit packer package
// Transfer types and mode codes shared by the packer core and its testbench.
//------------------------------------------------------------------------------
package pcbp_pkg;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       length_error;
    } t_out_item;

endpackage

@@ rtl/core/pcbp_code_table.sv @@
//------------------------------------------------------------------------------
// Prefix code bit packer code table
// One entry per symbol holding the code bits and length, registered read.
//------------------------------------------------------------------------------
module pcbp_code_table #(
    parameter int SYMBOLS = 256,
    parameter int CODE_W  = 32,
    parameter int LEN_W   = 6
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic                       i_rd_en,
    input  logic [$clog2(SYMBOLS)-1:0] i_addr,
    input  logic [CODE_W-1:0]          i_wr_code,
    input  logic [LEN_W-1:0]           i_wr_len,
    output logic [CODE_W-1:0]          o_rd_code,
    output logic [LEN_W-1:0]           o_rd_len
);

    logic [CODE_W+LEN_W-1:0] r_mem [SYMBOLS];
    logic [CODE_W+LEN_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_wr_code, i_wr_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rd_code = r_rd[CODE_W+LEN_W-1:LEN_W];
    assign o_rd_len  = r_rd[LEN_W-1:0];

endmodule

@@ rtl/core/prefix_code_bit_packer_core.sv @@
//------------------------------------------------------------------------------
// Prefix code bit packer core
// A result byte is offered from the result registers, loaded from the item
// register and the registered table read. Throughput: one item per cycle while
// each item yields at most one byte and the output is not stalled; an item with
// more bytes holds the input as the single result register set drains one byte
// per cycle while not stalled. Table read is one port, registered. Reset clears
// the bit buffer and all valid state; table entries are undefined until loaded.
//------------------------------------------------------------------------------
`include "prefix_code_bit_packer_core_defines.svh"

module prefix_code_bit_packer_core
    import pcbp_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int LL      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W   = $clog2(LL + 1);
    localparam int AW      = $clog2(SYMBOLS);
    localparam int CAT_W   = LL + 7;
    localparam int TW      = $clog2(LL + 8);
    localparam int RES_MAX = (LL + 7) / 8;
    localparam int CW      = $clog2(RES_MAX + 1);
    localparam int IW      = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
    localparam int NBW     = TW - 3;

    logic              in_acc;
    logic              in_range;
    logic              ld_err;
    logic [LL:0]       ld_mask;
    logic              wr_en;
    logic              rd_en;
    logic [LL-1:0]     wr_code;
    logic [LEN_W-1:0]  wr_len;
    logic [LL-1:0]     rd_code;
    logic [LEN_W-1:0]  rd_len;

    logic              r_a_valid;
    t_in_item          r_a;
    logic [6:0]        r_buf;
    logic [2:0]        r_bcnt;
    t_out_item         r_res [RES_MAX];
    logic [CW-1:0]     r_cnt;
    logic [IW-1:0]     r_idx;

    logic              n_a_valid;
    logic [6:0]        n_buf;
    logic [2:0]        n_bcnt;
    t_out_item         n_res [RES_MAX];
    logic [CW-1:0]     n_cnt;
    logic [IW-1:0]     n_idx;

    logic              last_take;
    logic              adv_ok;
    logic              a_fire;
    logic              a_range;
    logic [CAT_W-1:0]  cat;
    logic [CAT_W-1:0]  rest;
    logic [TW-1:0]     total;
    logic [NBW-1:0]    nb;
    logic [2:0]        tail;
    logic              flush_fire;
    logic              flush_out;

    assign in_range = ({1'b0, i_in_data.symbol} < 9'(SYMBOLS));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign ld_err   = (i_in_data.code_length > 6'(LL));
    assign ld_mask  = ({{LL{1'b0}}, 1'b1} << i_in_data.code_length) - 1'b1;
    assign wr_en    = in_acc && (i_in_data.mode == MODE_LOAD) && in_range;
    assign rd_en    = in_acc && (i_in_data.mode == MODE_ENCODE) && in_range;
    assign wr_code  = ld_err ? '0 : (i_in_data.code_bits[LL-1:0] & ld_mask[LL-1:0]);
    assign wr_len   = ld_err ? '0 : LEN_W'(i_in_data.code_length);

    pcbp_code_table #(
        .SYMBOLS (SYMBOLS),
        .CODE_W  (LL),
        .LEN_W   (LEN_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (i_in_data.symbol[AW-1:0]),
        .i_wr_code (wr_code),
        .i_wr_len  (wr_len),
        .o_rd_code (rd_code),
        .o_rd_len  (rd_len)
    );

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_res[r_idx];
    assign last_take   = o_out_valid && !i_out_stall && ((CW'(r_idx) + CW'(1'b1)) == r_cnt);
    assign adv_ok      = (r_cnt == '0) || last_take;
    assign o_in_stall  = r_a_valid && !adv_ok;
    assign a_fire      = r_a_valid && adv_ok;
    assign a_range     = ({1'b0, r_a.symbol} < 9'(SYMBOLS));
    assign flush_fire  = a_fire && (r_a.mode == MODE_FLUSH);
    assign flush_out   = flush_fire && (r_bcnt != 3'd0);

    assign cat   = CAT_W'(r_buf) | (CAT_W'(rd_code) << r_bcnt);
    assign total = TW'(r_bcnt) + TW'(rd_len);
    assign nb    = total[TW-1:3];
    assign tail  = total[2:0];
    assign rest  = cat >> {nb, 3'b000};

    always_comb begin
        n_a_valid = r_a_valid;
        n_buf     = r_buf;
        n_bcnt    = r_bcnt;
        n_res     = r_res;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        if (o_out_valid && !i_out_stall) begin
            if (last_take) begin
                n_cnt = '0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
        if (in_acc) begin
            n_a_valid = 1'b1;
        end else if (adv_ok) begin
            n_a_valid = 1'b0;
        end
        if (a_fire) begin
            n_cnt = '0;
            n_idx = '0;
            case (r_a.mode)
                MODE_LOAD: begin
                    if (a_range && (r_a.code_length > 6'(LL))) begin
                        n_res[0] = '{out_byte: 8'd0, last: 1'b0, length_error: 1'b1};
                        n_cnt    = CW'(1);
                    end
                end
                MODE_ENCODE: begin
                    if (a_range) begin
                        for (int k = 0; k < RES_MAX; k++) begin
                            n_res[k] = '{out_byte: cat[8*k +: 8], last: 1'b0,
                                         length_error: 1'b0};
                        end
                        n_cnt  = CW'(nb);
                        n_bcnt = tail;
                        n_buf  = rest[6:0] & ((7'd1 << tail) - 7'd1);
                    end
                end
                MODE_FLUSH: begin
                    if (r_bcnt != 3'd0) begin
                        n_res[0] = '{out_byte: {1'b0, r_buf}, last: 1'b1,
                                     length_error: 1'b0};
                        n_cnt    = CW'(1);
                    end
                    n_buf  = '0;
                    n_bcnt = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_buf     <= '0;
            r_bcnt    <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_buf     <= n_buf;
            r_bcnt    <= n_bcnt;
            r_cnt     <= n_cnt;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_acc) begin
            r_a <= i_in_data;
        end
    end

    `PCBP_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(RES_MAX))
    `PCBP_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_cnt != '0, CW'(r_idx) < r_cnt)
    `PCBP_ASSERT_IMPL(a_buf_clean, i_clk, i_rst_n, 1'b1, (r_buf >> r_bcnt) == 7'd0)
    `PCBP_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n, flush_out, o_out_data.last && (r_cnt == CW'(1)))
    `PCBP_ASSERT_NEXT(a_flush_empty, i_clk, i_rst_n, flush_fire, r_bcnt == 3'd0)

endmodule

@@ bench/tb_prefix_code_bit_packer_core.sv @@
//------------------------------------------------------------------------------
// Prefix code bit packer core testbench
// Loads code table entries and encodes symbol streams through the packer,
// predicting every packed byte, flush byte and length error in step with each
// accepted input transfer and comparing each output transfer field by field.
// A directed table comes first, then random streams under varied idling.
//------------------------------------------------------------------------------
module tb_prefix_code_bit_packer_core;
    import pcbp_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         LEN_LIMIT     = 32;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         DIRECTED_ROWS = 24;

    localparam t_out_item NO_BYTE    = '{out_byte: 8'h00, last: 1'b0, length_error: 1'b0};
    localparam t_out_item ERROR_BYTE = '{out_byte: 8'h00, last: 1'b0, length_error: 1'b1};
    localparam t_out_item ONES_BYTE  = '{out_byte: 8'hFF, last: 1'b0, length_error: 1'b0};
    localparam t_out_item A5_BYTE    = '{out_byte: 8'hA5, last: 1'b0, length_error: 1'b0};

    typedef struct packed {
        t_in_item   item;
        logic       typed;
        logic [2:0] typed_count;
        t_out_item  typed_byte;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    logic [31:0] code_table [256];
    logic [5:0]  length_table [256];
    bit          sym_loaded [256];
    int          loaded_syms [$];
    logic [38:0] bit_buf = '0;
    int unsigned bit_cnt = 0;

    t_out_item fresh_bytes [$];
    t_out_item pending_bytes [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles    = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{'{MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1'b1, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32}, 1'b0, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd255, 32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd1,   32'hFFFF_FFA5, 6'd8},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd2,   32'h0000_0005, 6'd3},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd3,   32'h1234_5678, 6'd33}, 1'b1, 3'd1, ERROR_BYTE},
        '{'{MODE_LOAD,   8'd4,   32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd1, ERROR_BYTE},
        '{'{MODE_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd1,   32'h0000_0000, 6'd0},  1'b1, 3'd1, A5_BYTE},
        '{'{MODE_ENCODE, 8'd255, 32'h0000_0000, 6'd0},  1'b1, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd3,   32'h0000_0000, 6'd0},  1'b1, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1'b1, 3'd4, ONES_BYTE},
        '{'{MODE_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1'b1, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd5,   32'hFFFF_FFFF, 6'd7},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd5,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd2,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1'b0, 3'd0, NO_BYTE},
        '{'{MODE_LOAD,   8'd0,   32'h0000_0000, 6'd32}, 1'b0, 3'd0, NO_BYTE},
        '{'{MODE_ENCODE, 8'd0,   32'h0000_0000, 6'd0},  1'b1, 3'd4, NO_BYTE},
        '{'{MODE_FLUSH,  8'd0,   32'h0000_0000, 6'd0},  1'b1, 3'd0, NO_BYTE}
    };

    prefix_code_bit_packer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void pack_item(input t_in_item it);
        logic [38:0] code_ext;
        int unsigned len;
        case (it.mode)
            MODE_LOAD: begin
                if (it.code_length > LEN_LIMIT) begin
                    code_table[it.symbol]   = '0;
                    length_table[it.symbol] = '0;
                    fresh_bytes.push_back(ERROR_BYTE);
                end else begin
                    code_table[it.symbol]   = it.code_bits;
                    length_table[it.symbol] = it.code_length;
                end
                if (!sym_loaded[it.symbol]) begin
                    sym_loaded[it.symbol] = 1'b1;
                    loaded_syms.push_back(it.symbol);
                end
            end
            MODE_ENCODE: begin
                len      = length_table[it.symbol];
                code_ext = 39'(code_table[it.symbol]);
                if (len < 32) begin
                    code_ext &= (39'd1 << len) - 39'd1;
                end
                bit_buf  = (bit_buf & ((39'd1 << bit_cnt) - 39'd1)) | (code_ext << bit_cnt);
                bit_cnt += len;
                while (bit_cnt >= 8) begin
                    fresh_bytes.push_back('{out_byte: bit_buf[7:0], last: 1'b0,
                                            length_error: 1'b0});
                    bit_buf = bit_buf >> 8;
                    bit_cnt -= 8;
                end
            end
            MODE_FLUSH: begin
                if (bit_cnt != 0) begin
                    bit_buf &= (39'd1 << bit_cnt) - 39'd1;
                    fresh_bytes.push_back('{out_byte: bit_buf[7:0], last: 1'b1,
                                            length_error: 1'b0});
                end
                bit_buf = '0;
                bit_cnt = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        it.symbol      = 8'($urandom);
        it.code_bits   = $urandom;
        it.code_length = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 22 || loaded_syms.size() == 0) begin
            it.mode = MODE_LOAD;
            pick = $urandom_range(99);
            if (pick < 70) begin
                it.code_length = 6'($urandom_range(10, 1));
            end else if (pick < 90) begin
                it.code_length = 6'($urandom_range(LEN_LIMIT, 0));
            end
        end else if (pick < 86) begin
            it.mode   = MODE_ENCODE;
            it.symbol = 8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        end else if (pick < 96) begin
            it.mode = MODE_FLUSH;
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input int typed_count,
                             input t_out_item typed_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        fresh_bytes.delete();
        pack_item(it);
        if (typed) begin
            fresh_bytes.delete();
            repeat (typed_count) fresh_bytes.push_back(typed_byte);
        end
        foreach (fresh_bytes[k]) pending_bytes.push_back(fresh_bytes[k]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        t_in_item it;
        int       sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            it = random_item();
            send_item(it, 1'b0, 0, NO_BYTE);
            if (it.mode != MODE_UNUSED) sent++;
        end
        wait_drained();
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_transfers
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output transfer, expected none, actual %0h",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                check_field("out_byte", want.out_byte, o_out_data.out_byte);
                check_field("last", want.last, o_out_data.last);
                check_field("length_error", want.length_error, o_out_data.length_error);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed,
                      directed_rows[r].typed_count, directed_rows[r].typed_byte);
        end
        wait_drained();
        // The receiver holds off while the sender keeps offering transfers.
        hold_cycles = 80;
        run_random(32, 0, 0);
        run_random(30, 81, 0);
        run_random(32, 0, 81);
        run_random(30, 23, 23);
        if (pending_bytes.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("** prefix_code_bit_packer_core: PASSED **");
        end else begin
            $display("** prefix_code_bit_packer_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** prefix_code_bit_packer_core: FAILED **");
        $finish;
    end

endmodule
